@@ src/bfis_pkg.sv @@
// Shared constants for the Brainfuck instruction step block.
// Holds field widths, opcode characters, status and function codes.
// No dependencies.
package bfis_pkg;

   // Port field widths.
   localparam int CFG_W  = 11;
   localparam int ADDR_W = 10;
   localparam int CHAR_W = 8;
   localparam int STAT_W = 2;
   localparam int PC_W   = 11;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [STAT_W-1:0] status_type;

   // Instruction characters.
   localparam char_type CH_RIGHT = 8'h3E;
   localparam char_type CH_LEFT  = 8'h3C;
   localparam char_type CH_INC   = 8'h2B;
   localparam char_type CH_DEC   = 8'h2D;
   localparam char_type CH_OUT   = 8'h2E;
   localparam char_type CH_OPEN  = 8'h5B;
   localparam char_type CH_CLOSE = 8'h5D;

   // Run status codes.
   localparam status_type ST_RUNNING = 2'd0;
   localparam status_type ST_HALTED  = 2'd1;
   localparam status_type ST_ERROR   = 2'd2;

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

endpackage

@@ src/brainfuck_instruction_step.sv @@
// Brainfuck processor: program memory, data tape and the step sequencer.
// Depends on bfis_pkg.
//
// A request transaction either loads one program character (func 0) or runs
// one instruction (func 1) while the status is running, and every request
// yields exactly one response transaction carrying the output byte, the run
// status and the instruction position after the request. Program and tape
// sit in two synchronous RAMs with registered read ports. After reset the
// block zeroes every tape cell and accepts no request meanwhile
// (program_length writes are taken at any time). A running step issues the
// program and tape reads on acceptance, does the read-modify-write of the
// tape cell and the pointers in S_EXEC, and registers the response in S_DONE,
// which waits until the output register is free; a load writes the program
// RAM in S_LOAD instead. A bracket that jumps adds a scan that reads the
// program RAM one entry per cycle. When PROG_DEPTH is below 1024 a load stays
// in S_LOAD, subtracting PROG_DEPTH from the address until it fits. The next
// request is taken while a response still waits in the output register.
module brainfuck_instruction_step #(
   parameter int PROG_DEPTH = 1024,
   parameter int TAPE_DEPTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration.
   input  logic                         csr_write_enable,
   input  logic [bfis_pkg::CFG_W-1:0]   csr_write_data,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [bfis_pkg::ADDR_W-1:0]  req_load_address,
   input  logic [bfis_pkg::CHAR_W-1:0]  req_program_char,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_out_valid,
   output logic [bfis_pkg::CHAR_W-1:0]  rsp_out_byte,
   output logic [bfis_pkg::STAT_W-1:0]  rsp_run_status,
   output logic [bfis_pkg::PC_W-1:0]    rsp_program_counter
);
   import bfis_pkg::*;

   localparam int PA_W = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
   localparam int IP_W = $clog2(PROG_DEPTH + 1);
   localparam int TA_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int WL_W = (IP_W > CFG_W) ? IP_W : CFG_W;
   localparam int LA_W = (IP_W > ADDR_W) ? IP_W : ADDR_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_SCANF = 3'd4;
   localparam logic [2:0] S_SCANB = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CFG_W-1:0]  plen_ff, plen_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [TA_W-1:0]   dp_ff, dp_in;
   logic              err_ff, err_in;
   logic [TA_W-1:0]   clr_ff, clr_in;
   logic [IP_W-1:0]   scan_pos_ff, scan_pos_in;
   logic [IP_W-1:0]   depth_ff, depth_in;
   logic [ADDR_W-1:0] laddr_ff, laddr_in;
   char_type          lchar_ff, lchar_in;
   logic              ovalid_ff, ovalid_in;
   char_type          obyte_ff, obyte_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_out_valid_ff, rsp_out_valid_in;
   char_type          rsp_out_byte_ff, rsp_out_byte_in;
   status_type        rsp_run_status_ff, rsp_run_status_in;
   logic [PC_W-1:0]   rsp_pc_ff, rsp_pc_in;

   // Memories and their ports.
   char_type          prog_mem [PROG_DEPTH];
   char_type          tape_mem [TAPE_DEPTH];
   char_type          prog_rdata_ff;
   char_type          tape_rdata_ff;
   logic              prog_we, prog_re;
   logic [PA_W-1:0]   prog_waddr, prog_raddr;
   logic              tape_we, tape_re;
   logic [TA_W-1:0]   tape_waddr;
   char_type          tape_wdata;

   // Derived control values.
   logic [IP_W-1:0]   eff_len;
   status_type        status_now;
   logic [IP_W-1:0]   ip_next;
   logic [IP_W-1:0]   scan_next;
   logic [TA_W-1:0]   dp_inc, dp_dec;
   logic              laddr_big;

   // Effective length is program_length clamped to the program memory depth.
   always_comb begin
      if (WL_W'(plen_ff) >= WL_W'(PROG_DEPTH)) begin
         eff_len = IP_W'(PROG_DEPTH);
      end else begin
         eff_len = IP_W'(plen_ff);
      end
   end

   // Status as seen from the current state; error wins over halt.
   always_comb begin
      if (err_ff) begin
         status_now = ST_ERROR;
      end else if (ip_ff >= eff_len) begin
         status_now = ST_HALTED;
      end else begin
         status_now = ST_RUNNING;
      end
   end

   assign ip_next   = ip_ff + 1'b1;
   assign scan_next = scan_pos_ff + 1'b1;
   assign dp_inc    = (dp_ff == TA_W'(TAPE_DEPTH - 1)) ? '0 : dp_ff + 1'b1;
   assign dp_dec    = (dp_ff == '0) ? TA_W'(TAPE_DEPTH - 1) : dp_ff - 1'b1;
   assign laddr_big = LA_W'(laddr_ff) >= LA_W'(PROG_DEPTH);

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer next-state logic.
   always_comb begin
      state_in          = state_ff;
      plen_in           = plen_ff;
      ip_in             = ip_ff;
      dp_in             = dp_ff;
      err_in            = err_ff;
      clr_in            = clr_ff;
      scan_pos_in       = scan_pos_ff;
      depth_in          = depth_ff;
      laddr_in          = laddr_ff;
      lchar_in          = lchar_ff;
      ovalid_in         = ovalid_ff;
      obyte_in          = obyte_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_out_valid_in  = rsp_out_valid_ff;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_run_status_in = rsp_run_status_ff;
      rsp_pc_in         = rsp_pc_ff;

      prog_we    = 1'b0;
      prog_waddr = PA_W'(laddr_ff);
      prog_re    = 1'b0;
      prog_raddr = ip_ff[PA_W-1:0];
      tape_we    = 1'b0;
      tape_waddr = dp_ff;
      tape_wdata = tape_rdata_ff;
      tape_re    = 1'b0;

      if (csr_write_enable) begin
         plen_in = csr_write_data;
      end

      // The response register drains independently of the sequencer.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Zero the tape one entry per cycle after reset.
         S_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            tape_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == TA_W'(TAPE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               ovalid_in = 1'b0;
               obyte_in  = '0;
               if (req_func == FUNC_LOAD) begin
                  laddr_in = req_load_address;
                  lchar_in = req_program_char;
                  state_in = S_LOAD;
               end else if (status_now == ST_RUNNING) begin
                  prog_re  = 1'b1;
                  tape_re  = 1'b1;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Reduce the address modulo the program depth, then write.
         S_LOAD: begin
            if (laddr_big) begin
               laddr_in = ADDR_W'(LA_W'(laddr_ff) - LA_W'(PROG_DEPTH));
            end else begin
               prog_we  = 1'b1;
               state_in = S_DONE;
            end
         end

         // Decode the instruction with the current cell in hand.
         S_EXEC: begin
            state_in = S_DONE;
            case (prog_rdata_ff)
               CH_RIGHT: begin
                  dp_in = dp_inc;
                  ip_in = ip_next;
               end
               CH_LEFT: begin
                  dp_in = dp_dec;
                  ip_in = ip_next;
               end
               CH_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata_ff + 1'b1;
                  ip_in      = ip_next;
               end
               CH_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata_ff - 1'b1;
                  ip_in      = ip_next;
               end
               CH_OUT: begin
                  ovalid_in = 1'b1;
                  obyte_in  = tape_rdata_ff;
                  ip_in     = ip_next;
               end
               CH_OPEN: begin
                  if (tape_rdata_ff != '0) begin
                     ip_in = ip_next;
                  end else if (ip_next >= eff_len) begin
                     err_in = 1'b1;
                  end else begin
                     scan_pos_in = ip_next;
                     depth_in    = '0;
                     prog_re     = 1'b1;
                     prog_raddr  = ip_next[PA_W-1:0];
                     state_in    = S_SCANF;
                  end
               end
               CH_CLOSE: begin
                  if (ip_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     scan_pos_in = ip_ff - 1'b1;
                     depth_in    = '0;
                     prog_re     = 1'b1;
                     prog_raddr  = PA_W'(ip_ff - 1'b1);
                     state_in    = S_SCANB;
                  end
               end
               default: begin
                  ip_in = ip_next;
               end
            endcase
         end

         // Forward scan for the matching close bracket, one entry per cycle.
         S_SCANF: begin
            if (prog_rdata_ff == CH_CLOSE && depth_ff == '0) begin
               ip_in    = scan_next;
               state_in = S_DONE;
            end else begin
               if (prog_rdata_ff == CH_OPEN) begin
                  depth_in = depth_ff + 1'b1;
               end else if (prog_rdata_ff == CH_CLOSE) begin
                  depth_in = depth_ff - 1'b1;
               end
               if (scan_next >= eff_len) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  scan_pos_in = scan_next;
                  prog_re     = 1'b1;
                  prog_raddr  = scan_next[PA_W-1:0];
               end
            end
         end

         // Backward scan for the matching open bracket.
         S_SCANB: begin
            if (prog_rdata_ff == CH_OPEN && depth_ff == '0) begin
               ip_in    = scan_pos_ff;
               state_in = S_DONE;
            end else begin
               if (prog_rdata_ff == CH_CLOSE) begin
                  depth_in = depth_ff + 1'b1;
               end else if (prog_rdata_ff == CH_OPEN) begin
                  depth_in = depth_ff - 1'b1;
               end
               if (scan_pos_ff == '0) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  scan_pos_in = scan_pos_ff - 1'b1;
                  prog_re     = 1'b1;
                  prog_raddr  = PA_W'(scan_pos_ff - 1'b1);
               end
            end
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_out_valid_in  = ovalid_ff;
               rsp_out_byte_in   = obyte_ff;
               rsp_run_status_in = status_now;
               rsp_pc_in         = PC_W'(ip_ff);
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         plen_ff      <= '0;
         ip_ff        <= '0;
         dp_ff        <= '0;
         err_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         ip_ff        <= ip_in;
         dp_ff        <= dp_in;
         err_ff       <= err_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_pos_ff       <= scan_pos_in;
      depth_ff          <= depth_in;
      laddr_ff          <= laddr_in;
      lchar_ff          <= lchar_in;
      ovalid_ff         <= ovalid_in;
      obyte_ff          <= obyte_in;
      rsp_out_valid_ff  <= rsp_out_valid_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_run_status_ff <= rsp_run_status_in;
      rsp_pc_ff         <= rsp_pc_in;
   end

   // Program memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= lchar_ff;
      end
      if (prog_re) begin
         prog_rdata_ff <= prog_mem[prog_raddr];
      end
   end

   // Data tape: one write port, one registered read port at the data pointer.
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      if (tape_re) begin
         tape_rdata_ff <= tape_mem[dp_ff];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_valid       = rsp_out_valid_ff;
   assign rsp_out_byte        = rsp_out_byte_ff;
   assign rsp_run_status      = rsp_run_status_ff;
   assign rsp_program_counter = rsp_pc_ff;

endmodule
